[src/fwtag_pkg.sv]
// Shared types, constants and CRC helpers for the firmware image tag verifier.
// No dependencies; every other file in src depends on this package.
package fwtag_pkg;

  localparam int unsigned OFFSET_W   = 16;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned TAG_BYTES  = 36;
  localparam int unsigned TAG_IDX_W  = 6;

  // Tag layout, byte offsets inside the tag
  localparam int unsigned HEAD_LEN   = 12;
  localparam int unsigned LEN_AT     = 16;
  localparam int unsigned APPCRC_AT  = 20;
  localparam int unsigned SELFCRC_AT = 24;
  localparam int unsigned END_AT     = 28;
  localparam int unsigned END_LEN    = 4;

  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 16'h0400;
  localparam logic [WORD_W-1:0]   CRC_POLY     = 32'hEDB8_8320;
  localparam logic [WORD_W-1:0]   CRC_ONES     = 32'hFFFF_FFFF;

  // Head magic: eleven ASCII characters and a terminating zero
  localparam logic [7:0] HEAD_MAGIC [HEAD_LEN] = '{
    8'h4C, 8'h49, 8'h4D, 8'h45, 8'h2D, 8'h54,
    8'h41, 8'h47, 8'h2D, 8'h53, 8'h54, 8'h00
  };
  // End magic: "END" and a terminating zero
  localparam logic [7:0] END_MAGIC [END_LEN] = '{8'h45, 8'h4E, 8'h44, 8'h00};

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_HEAD_BAD = 3'd2,
    ST_END_BAD  = 3'd3,
    ST_TAG_CRC  = 3'd4,
    ST_APP_CRC  = 3'd5,
    ST_LEN_BAD  = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    status_t           status;
    logic [WORD_W-1:0] computed_app_crc;
    logic [WORD_W-1:0] counted_length;
    logic [WORD_W-1:0] image_version;
  } result_t;

  // Reflected CRC-32, one byte unrolled over eight bit steps
  function automatic logic [WORD_W-1:0] crc_feed(input logic [WORD_W-1:0] crc,
                                                 input logic [7:0] b);
    logic [WORD_W-1:0] r;
    r = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  // Replace one little-endian byte lane of a word
  function automatic logic [WORD_W-1:0] put_lane(input logic [WORD_W-1:0] w,
                                                 input logic [1:0] lane,
                                                 input logic [7:0] b);
    logic [WORD_W-1:0] r;
    r = w;
    r[{lane, 3'b000} +: 8] = b;
    return r;
  endfunction

endpackage

[src/fwtag_if.sv]
// Valid/ready channel interfaces for image bytes in and verdicts out.
// Depends on fwtag_pkg for field widths and the status type.
interface fwtag_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface fwtag_out_if;
  logic                            valid;
  logic                            ready;
  fwtag_pkg::status_t              status;
  logic [fwtag_pkg::WORD_W-1:0]    computed_app_crc;
  logic [fwtag_pkg::WORD_W-1:0]    counted_length;
  logic [fwtag_pkg::WORD_W-1:0]    image_version;

  modport source (output valid, status, computed_app_crc, counted_length, image_version,
                  input ready);
  modport sink   (input valid, status, computed_app_crc, counted_length, image_version,
                  output ready);
endinterface

[src/fwtag_in_stage.sv]
// Input register for image bytes; refills in the same cycle it drains.
// Depends on fwtag_pkg (item_t).
module fwtag_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  fwtag_pkg::item_t  in_item,
  input  logic              take,
  output logic              held_valid,
  output fwtag_pkg::item_t  held_item
);
  import fwtag_pkg::*;

  // accept whenever the held item leaves this cycle or the slot is empty
  assign in_ready = !held_valid || take;

  // hold valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // hold payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_item <= in_item;
    end
  end

endmodule

[src/fwtag_core.sv]
// Per-byte image state: position, both CRCs, magic checks, tag words, verdict.
// Depends on fwtag_pkg (CRC helpers, tag layout, status codes).
module fwtag_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [fwtag_pkg::OFFSET_W-1:0]   cfg_wdata,
  input  logic                             take,
  input  fwtag_pkg::item_t                 item,
  output logic                             res_valid,
  output fwtag_pkg::result_t               res
);
  import fwtag_pkg::*;

  logic [OFFSET_W-1:0]  tag_base;
  logic [WORD_W-1:0]    pos, pos_next;
  logic [WORD_W-1:0]    app_crc, app_crc_next;
  logic [WORD_W-1:0]    tag_crc, tag_crc_next;
  logic                 head_ok, head_ok_next;
  logic                 end_ok, end_ok_next;
  logic [WORD_W-1:0]    ver_word, ver_word_next;
  logic [WORD_W-1:0]    len_word, len_word_next;
  logic [WORD_W-1:0]    appcrc_word, appcrc_word_next;
  logic [WORD_W-1:0]    selfcrc_word, selfcrc_word_next;

  logic [WORD_W-1:0]    off_ext;
  logic [WORD_W-1:0]    diff;
  logic                 in_tag;
  logic [TAG_IDX_W-1:0] k;
  logic [WORD_W-1:0]    app_final;
  logic [WORD_W:0]      min_len;
  logic [7:0]           b;

  assign b       = item.data_byte;
  assign off_ext = {{(WORD_W-OFFSET_W){1'b0}}, tag_base};
  assign diff    = pos - off_ext;
  assign in_tag  = (pos != CRC_ONES) && (pos >= off_ext) && (diff < WORD_W'(TAG_BYTES));
  assign k       = diff[TAG_IDX_W-1:0];

  // route the byte into the tag fields or the application CRC
  always_comb begin
    tag_crc_next      = tag_crc;
    app_crc_next      = app_crc;
    head_ok_next      = head_ok;
    end_ok_next       = end_ok;
    ver_word_next     = ver_word;
    len_word_next     = len_word;
    appcrc_word_next  = appcrc_word;
    selfcrc_word_next = selfcrc_word;
    if (in_tag) begin
      if (k < TAG_IDX_W'(SELFCRC_AT)) begin
        tag_crc_next = crc_feed(tag_crc, b);
      end
      priority if (k < TAG_IDX_W'(HEAD_LEN)) begin
        if (b != HEAD_MAGIC[k[3:0]]) head_ok_next = 1'b0;
      end else if (k < TAG_IDX_W'(LEN_AT)) begin
        ver_word_next = put_lane(ver_word, k[1:0], b);
      end else if (k < TAG_IDX_W'(APPCRC_AT)) begin
        len_word_next = put_lane(len_word, k[1:0], b);
      end else if (k < TAG_IDX_W'(SELFCRC_AT)) begin
        appcrc_word_next = put_lane(appcrc_word, k[1:0], b);
      end else if (k < TAG_IDX_W'(END_AT)) begin
        selfcrc_word_next = put_lane(selfcrc_word, k[1:0], b);
      end else if (k < TAG_IDX_W'(END_AT + END_LEN)) begin
        if (b != END_MAGIC[k[1:0]]) end_ok_next = 1'b0;
      end else begin
        // reserved tag bytes: ignore
        head_ok_next = head_ok;
      end
    end else begin
      app_crc_next = crc_feed(app_crc, b);
    end
  end

  // advance the saturating byte count
  assign pos_next = (pos == CRC_ONES) ? pos : pos + WORD_W'(1);

  // grade the image in check order
  assign app_final = app_crc_next ^ CRC_ONES;
  assign min_len   = {1'b0, off_ext} + (WORD_W+1)'(TAG_BYTES);

  always_comb begin
    priority if ({1'b0, pos_next} < min_len)           res.status = ST_SHORT;
    else if (!head_ok_next)                            res.status = ST_HEAD_BAD;
    else if (!end_ok_next)                             res.status = ST_END_BAD;
    else if ((tag_crc_next ^ CRC_ONES) != selfcrc_word_next)
                                                       res.status = ST_TAG_CRC;
    else if (app_final != appcrc_word_next)            res.status = ST_APP_CRC;
    else if (pos_next != len_word_next)                res.status = ST_LEN_BAD;
    else                                               res.status = ST_OK;
    res.computed_app_crc = app_final;
    res.counted_length   = pos_next;
    res.image_version    = ver_word_next;
  end

  assign res_valid = take && item.last_byte;

  // hold the offset register and the image state; drop it after the final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_base     <= OFFSET_RESET;
      pos          <= '0;
      app_crc      <= CRC_ONES;
      tag_crc      <= CRC_ONES;
      head_ok      <= 1'b1;
      end_ok       <= 1'b1;
      ver_word     <= '0;
      len_word     <= '0;
      appcrc_word  <= '0;
      selfcrc_word <= '0;
    end else begin
      if (cfg_we) begin
        tag_base <= cfg_wdata;
      end
      if (take) begin
        if (item.last_byte) begin
          pos          <= '0;
          app_crc      <= CRC_ONES;
          tag_crc      <= CRC_ONES;
          head_ok      <= 1'b1;
          end_ok       <= 1'b1;
          ver_word     <= '0;
          len_word     <= '0;
          appcrc_word  <= '0;
          selfcrc_word <= '0;
        end else begin
          pos          <= pos_next;
          app_crc      <= app_crc_next;
          tag_crc      <= tag_crc_next;
          head_ok      <= head_ok_next;
          end_ok       <= end_ok_next;
          ver_word     <= ver_word_next;
          len_word     <= len_word_next;
          appcrc_word  <= appcrc_word_next;
          selfcrc_word <= selfcrc_word_next;
        end
      end
    end
  end

  // a final byte always starts the next image from position zero
  a_restart: assert property (@(posedge clk) disable iff (rst)
    take && item.last_byte |=> pos == '0 && app_crc == CRC_ONES && tag_crc == CRC_ONES)
    else $error("image state not cleared after final byte");

  // a non-final byte moves the position by one until it saturates
  a_count: assert property (@(posedge clk) disable iff (rst)
    take && !item.last_byte && pos != CRC_ONES |=> pos == $past(pos) + WORD_W'(1))
    else $error("byte position did not advance");

endmodule

[src/firmware_image_tag_crc_verifier.sv]
// Top level of the firmware image tag verifier: input register, image core, result register.
// Depends on fwtag_pkg, fwtag_if, fwtag_in_stage and fwtag_core.
//
// Image bytes enter one per cycle on byte_in, the final byte marked by last_byte. A 36-byte
// tag at the programmed tag base (written through cfg_we/cfg_wdata, reset 0x400) is parsed:
// head magic, version, length, application CRC, tag CRC, end magic. Reflected CRC-32 runs
// over every byte outside the tag; a second CRC-32 covers tag bytes 0 to 23. On the final
// byte one verdict leaves on result: 0 ok, 1 too short, 2 head bad, 3 end bad, 4 tag CRC
// bad, 5 application CRC bad, 6 length bad, with the computed CRC, byte count and version.
// The block takes one byte every cycle while intake is not stalled. A final byte is held in the
// input register while the byte-wide unrolled CRC and the checks settle ahead of the result
// register, which then holds the verdict on result. A verdict left waiting stalls intake only
// when the next final byte reaches the core. Write the tag base only between images.
module firmware_image_tag_crc_verifier (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fwtag_pkg::OFFSET_W-1:0]  cfg_wdata,
  fwtag_in_if.sink                        byte_in,
  fwtag_out_if.source                     result
);
  import fwtag_pkg::*;

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    take;
  logic    res_valid;
  result_t res;
  logic    out_valid;
  result_t out_data;

  assign in_item.data_byte = byte_in.data_byte;
  assign in_item.last_byte = byte_in.last_byte;

  // a final byte moves on only when the result register has room
  assign take = held_valid && (!held_item.last_byte || !out_valid || result.ready);

  fwtag_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (byte_in.valid),
    .in_ready   (byte_in.ready),
    .in_item    (in_item),
    .take       (take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  fwtag_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .take      (take),
    .item      (held_item),
    .res_valid (res_valid),
    .res       (res)
  );

  // hold the verdict until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data <= res;
    end
  end

  assign result.valid            = out_valid;
  assign result.status           = out_data.status;
  assign result.computed_app_crc = out_data.computed_app_crc;
  assign result.counted_length   = out_data.counted_length;
  assign result.image_version    = out_data.image_version;

  // a new verdict never lands on one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!out_valid || result.ready))
    else $error("verdict overwritten while stalled");

  // the input register only drains a byte it holds
  a_take_held: assert property (@(posedge clk) disable iff (rst)
    take |-> held_valid)
    else $error("core consumed an empty input register");

endmodule
